FILE: design/greedy_agent_schedule_cost_unit_assert.svh
// Assertion macros shared by the checker of the schedule cost unit.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef GREEDY_AGENT_SCHEDULE_COST_UNIT_ASSERT_SVH
`define GREEDY_AGENT_SCHEDULE_COST_UNIT_ASSERT_SVH

// Checked only outside reset.
`define GASC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define GASC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/gasc_pkg.sv
// Package of the greedy agent schedule cost unit: widths, codes, types.
// Used by every other file of the block but the assertion header; depends on nothing.
package gasc_pkg;

    localparam int MAX_AGENTS  = 8;
    localparam int TIME_WIDTH  = 48;
    localparam int COST_WIDTH  = 63;
    localparam int COUNT_WIDTH = $clog2(MAX_AGENTS + 1);

    typedef logic signed [TIME_WIDTH-1:0] t_time;
    typedef logic [COST_WIDTH-1:0]        t_cost;
    typedef logic [COUNT_WIDTH-1:0]       t_count;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    localparam t_time TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
    localparam t_time TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};
    localparam t_cost COST_MAX = {COST_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LOAD_FULL = 2'd1,
        ST_ADD_EMPTY = 2'd2,
        ST_END_SAT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_END,
        S_COST,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic latch;
        logic calc_end;
        logic calc_cost;
        logic commit;
    } t_dp_cmd;

endpackage

FILE: design/gasc_in_if.sv
// Input channel of the schedule cost unit: valid, ready and one command item.
// Depends on gasc_pkg.
interface gasc_in_if import gasc_pkg::*;;
    logic  valid;
    logic  ready;
    logic  command;
    t_time agent_ready_time;
    t_time start_time;
    t_time finish_time;

    modport source (output valid, command, agent_ready_time, start_time, finish_time,
                    input ready);
    modport sink (input valid, command, agent_ready_time, start_time, finish_time,
                  output ready);
endinterface

FILE: design/gasc_out_if.sv
// Result channel of the schedule cost unit: valid, ready and one result item.
// Depends on gasc_pkg.
interface gasc_out_if import gasc_pkg::*;;
    logic       valid;
    logic       ready;
    t_cost      run_cost;
    t_time      earliest_end;
    t_count     agent_count;
    logic [1:0] status;

    modport source (output valid, run_cost, earliest_end, agent_count, status,
                    input ready);
    modport sink (input valid, run_cost, earliest_end, agent_count, status,
                  output ready);
endinterface

FILE: design/gasc_ctrl.sv
// Controller of the schedule cost unit: sequences one transaction through the datapath.
// Depends on gasc_pkg; drives the datapath command struct and both handshakes.
module gasc_ctrl import gasc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_commit_ok;

    assign w_commit_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                n_state = S_COST;
            end
            S_COST: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_commit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_END: begin
                o_cmd.calc_end = 1'b1;
            end
            S_COST: begin
                o_cmd.calc_cost = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = w_commit_ok;
                if (w_commit_ok) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/gasc_datapath.sv
// Datapath of the schedule cost unit: sorted end-time list, new end, cost, result register.
// Depends on gasc_pkg; steered by the command struct from gasc_ctrl.
module gasc_datapath import gasc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic       i_command,
    input  t_time      i_agent_ready_time,
    input  t_time      i_start_time,
    input  t_time      i_finish_time,
    output t_cost      o_run_cost,
    output t_time      o_earliest_end,
    output t_count     o_agent_count,
    output logic [1:0] o_status
);

    logic  r_command;
    t_time r_ready_time;
    t_time r_start;
    t_time r_finish;
    t_time r_new_end;
    logic  r_sat;
    logic [TIME_WIDTH-1:0] r_inc;

    t_time  r_end [MAX_AGENTS];
    t_time  n_end [MAX_AGENTS];
    t_time  w_ins [MAX_AGENTS];
    t_time  w_mov [MAX_AGENTS];
    logic   w_vld [MAX_AGENTS];
    logic   w_gt  [MAX_AGENTS];
    logic   w_lt  [MAX_AGENTS];

    t_count r_count;
    t_count n_count;
    t_cost  r_cost;
    t_cost  n_cost;

    t_cost      r_out_cost;
    t_time      r_out_end;
    t_count     r_out_count;
    logic [1:0] r_out_status;

    logic [TIME_WIDTH+1:0] w_sum;
    logic                  w_fits;
    t_time                 w_new_end;
    logic [TIME_WIDTH:0]   w_diff;
    logic [TIME_WIDTH-1:0] w_inc;
    logic [COST_WIDTH:0]   w_cost_wide;
    logic                  w_is_load;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_do_load;
    logic                  w_do_add;
    t_status               w_status;

    // New end of the front agent, clamped to the time range.
    assign w_sum = {{2{r_end[0][TIME_WIDTH-1]}}, r_end[0]}
                 + {{2{r_finish[TIME_WIDTH-1]}}, r_finish}
                 - {{2{r_start[TIME_WIDTH-1]}}, r_start};
    assign w_fits = (w_sum[TIME_WIDTH+1:TIME_WIDTH-1] == 3'b000)
                 || (w_sum[TIME_WIDTH+1:TIME_WIDTH-1] == 3'b111);
    assign w_new_end = w_fits ? t_time'(w_sum[TIME_WIDTH-1:0])
                     : (w_sum[TIME_WIDTH+1] ? TIME_MIN : TIME_MAX);

    // Cost increment is the positive part of new end minus start.
    assign w_diff = {r_new_end[TIME_WIDTH-1], r_new_end} - {r_start[TIME_WIDTH-1], r_start};
    assign w_inc  = (!w_diff[TIME_WIDTH] && (w_diff != '0)) ? w_diff[TIME_WIDTH-1:0] : '0;

    assign w_is_load = (r_command == CMD_LOAD);
    assign w_full    = (r_count == t_count'(MAX_AGENTS));
    assign w_empty   = (r_count == '0);
    assign w_do_load = w_is_load && !w_full;
    assign w_do_add  = !w_is_load && !w_empty;

    genvar j;
    generate
        for (j = 0; j < MAX_AGENTS; j++) begin : g_slot
            assign w_vld[j] = (t_count'(j) < r_count);
            assign w_gt[j]  = (r_end[j] > r_ready_time);
            assign w_lt[j]  = (r_end[j] < r_new_end);

            // Loaded time goes after existing equal ends.
            if (j == 0) begin : g_ins_first
                assign w_ins[j] = (w_vld[j] && !w_gt[j]) ? r_end[j] : r_ready_time;
            end else begin : g_ins_rest
                assign w_ins[j] = (w_vld[j] && !w_gt[j]) ? r_end[j]
                                : ((w_vld[j-1] && w_gt[j-1]) ? r_end[j-1] : r_ready_time);
            end

            // Front agent moves back ahead of the first end not below its new end.
            if (j == MAX_AGENTS - 1) begin : g_mov_last
                assign w_mov[j] = (j == 0 || (w_vld[j] && w_lt[j])) ? r_new_end : r_end[j];
            end else begin : g_mov_rest
                assign w_mov[j] = (w_vld[j+1] && w_lt[j+1]) ? r_end[j+1]
                                : ((j == 0 || (w_vld[j] && w_lt[j])) ? r_new_end : r_end[j]);
            end

            assign n_end[j] = w_do_load ? w_ins[j] : (w_do_add ? w_mov[j] : r_end[j]);
        end
    endgenerate

    assign n_count     = w_do_load ? r_count + t_count'(1) : r_count;
    assign w_cost_wide = {1'b0, r_cost} + (COST_WIDTH+1)'(r_inc);

    always_comb begin
        n_cost = r_cost;
        if (w_do_add) begin
            n_cost = w_cost_wide[COST_WIDTH] ? COST_MAX : w_cost_wide[COST_WIDTH-1:0];
        end
    end

    always_comb begin
        if (w_is_load) begin
            w_status = w_full ? ST_LOAD_FULL : ST_OK;
        end else if (w_empty) begin
            w_status = ST_ADD_EMPTY;
        end else begin
            w_status = r_sat ? ST_END_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_command    <= i_command;
            r_ready_time <= i_agent_ready_time;
            r_start      <= i_start_time;
            r_finish     <= i_finish_time;
        end
        if (i_cmd.calc_end) begin
            r_new_end <= w_new_end;
            r_sat     <= !w_fits;
        end
        if (i_cmd.calc_cost) begin
            r_inc <= w_inc;
        end
        if (i_cmd.commit) begin
            r_end        <= n_end;
            r_out_cost   <= n_cost;
            r_out_end    <= (n_count != '0) ? n_end[0] : '0;
            r_out_count  <= n_count;
            r_out_status <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cost  <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            r_cost  <= n_cost;
        end
    end

    assign o_run_cost     = r_out_cost;
    assign o_earliest_end = r_out_end;
    assign o_agent_count  = r_out_count;
    assign o_status       = r_out_status;

endmodule

FILE: design/greedy_agent_schedule_cost_unit.sv
// Greedy agent schedule cost unit: usage notes below.
// Instantiates gasc_ctrl and gasc_datapath; depends on gasc_pkg and both channel interfaces.
//
// Input channel i_in carries one command per transaction: a load inserts an agent's
// ready time into a sorted list of up to eight end times, an add gives a task to the
// earliest-finishing agent and charges max(0, new end - start) to a saturating cost.
// Output channel o_out returns exactly one result per command: running cost, earliest
// end, agent count and status.
// The result is valid once the controller's commit step has run: the accepting edge captures
// the command, the end step forms the clamped new end, the cost step the cost increment, and
// the commit step updates the list and the result register. The controller walks these steps
// one command at a time, so a new command is accepted only after the commit step of the one
// before it.
// A finished result waits in the output register; the next command is accepted and
// worked on meanwhile, and only its final step waits while the receiver stalls.
// Reset empties the agent list, clears the cost and drops the output valid.
module greedy_agent_schedule_cost_unit import gasc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gasc_in_if.sink           i_in,
    gasc_out_if.source        o_out
);

    t_dp_cmd w_cmd;

    gasc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    gasc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_command          (i_in.command),
        .i_agent_ready_time (i_in.agent_ready_time),
        .i_start_time       (i_in.start_time),
        .i_finish_time      (i_in.finish_time),
        .o_run_cost         (o_out.run_cost),
        .o_earliest_end     (o_out.earliest_end),
        .o_agent_count      (o_out.agent_count),
        .o_status           (o_out.status)
    );

endmodule

FILE: design/gasc_checker.sv
// Port-level checker of the schedule cost unit and its bind to the top level.
// Depends on gasc_pkg and greedy_agent_schedule_cost_unit_assert.svh.
`include "greedy_agent_schedule_cost_unit_assert.svh"

module gasc_checker import gasc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_cost      i_run_cost,
    input t_time      i_earliest_end,
    input t_count     i_agent_count,
    input logic [1:0] i_status
);

    logic [COST_WIDTH+TIME_WIDTH+COUNT_WIDTH+1:0] w_result;
    logic                                         w_stall;
    logic                                         w_count_ok;
    logic                                         w_full_flag;
    logic                                         w_full_count;
    logic                                         w_empty_flag;
    logic                                         w_empty_result;

    assign w_result       = {i_run_cost, i_earliest_end, i_agent_count, i_status};
    assign w_stall        = i_out_valid && !i_out_ready;
    assign w_count_ok     = (i_agent_count <= t_count'(MAX_AGENTS));
    assign w_full_flag    = i_out_valid && (i_status == ST_LOAD_FULL);
    assign w_full_count   = (i_agent_count == t_count'(MAX_AGENTS));
    assign w_empty_flag   = i_out_valid && (i_status == ST_ADD_EMPTY);
    assign w_empty_result = (i_agent_count == '0) && (i_earliest_end == '0);

    `GASC_ASSERT_ALWAYS(a_reset_clears_valid, !i_rst_n |=> !i_out_valid, "valid after reset")
    `GASC_ASSERT(a_hold, w_stall |=> i_out_valid && $stable(w_result), "stalled result changed")
    `GASC_ASSERT(a_count_bound, i_out_valid |-> w_count_ok, "agent count too large")
    `GASC_ASSERT(a_full_flag, w_full_flag |-> w_full_count, "full flag with room left")
    `GASC_ASSERT(a_empty_flag, w_empty_flag |-> w_empty_result, "empty flag with agents")

endmodule

bind greedy_agent_schedule_cost_unit gasc_checker u_gasc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_run_cost     (o_out.run_cost),
    .i_earliest_end (o_out.earliest_end),
    .i_agent_count  (o_out.agent_count),
    .i_status       (o_out.status)
);
